### rtl/mes_pkg.sv
`default_nettype none

package mes_pkg;

    localparam int CAPACITY = 128;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int VAL_W    = 32;
    localparam int FILL_W   = 8;
    localparam int STAT_W   = 2;
    localparam int OUT_W    = ((VAL_W + STAT_W + FILL_W + 7) / 8) * 8;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    localparam logic signed [VAL_W-1:0] EMPTY_VALUE = -32'sd1;

    typedef struct packed {
        logic signed [VAL_W-1:0] removed_value;
        t_status                 status;
        logic [FILL_W-1:0]       fill_count;
    } t_result;

endpackage

`default_nettype wire

### rtl/mes_ram.sv
`default_nettype none

module mes_ram #(
    parameter int DEPTH  = 128,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/mes_engine.sv
`default_nettype none

module mes_engine
    import mes_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_item_valid,
    output logic                         o_item_ready,
    input  wire t_req                    i_req_type,
    input  wire logic signed [VAL_W-1:0] i_item_value,
    output logic                         o_res_valid,
    input  wire logic                    i_res_ready,
    output t_result                      o_res,
    output logic                         o_wr_en,
    output logic [ADDR_W-1:0]            o_wr_addr,
    output logic [VAL_W-1:0]             o_wr_data,
    output logic                         o_rd_en,
    output logic [ADDR_W-1:0]            o_rd_addr,
    input  wire logic [VAL_W-1:0]        i_rd_data
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic                    r_pend, n_pend;
    logic [CNT_W-1:0]        r_pend_idx, n_pend_idx;
    logic signed [VAL_W-1:0] r_best, n_best;
    logic [ADDR_W-1:0]       r_pos, n_pos;
    t_result                 r_res, n_res;

    assign o_item_ready = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res        = r_res;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_pend     = 1'b0;
        n_pend_idx = r_idx;
        n_best     = r_best;
        n_pos      = r_pos;
        n_res      = r_res;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_count[ADDR_W-1:0];
        o_wr_data  = i_item_value;
        o_rd_en    = 1'b0;
        o_rd_addr  = r_idx[ADDR_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    if (i_req_type == REQ_INSERT) begin
                        n_res.removed_value = '0;
                        if (r_count >= CNT_W'(CAPACITY)) begin
                            n_res.status = ST_FULL;
                        end else begin
                            o_wr_en      = 1'b1;
                            n_count      = r_count + 1'b1;
                            n_res.status = ST_OK;
                        end
                        n_res.fill_count = FILL_W'(n_count);
                        n_state          = S_DONE;
                    end else if (r_count == '0) begin
                        n_res.removed_value = EMPTY_VALUE;
                        n_res.status        = ST_EMPTY;
                        n_res.fill_count    = '0;
                        n_state             = S_DONE;
                    end else begin
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_rd_en = (r_idx < r_count);
                n_pend  = o_rd_en;
                if (o_rd_en) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_pend) begin
                    if (r_pend_idx == '0 || $signed(i_rd_data) > r_best) begin
                        n_best = $signed(i_rd_data);
                        n_pos  = r_pend_idx[ADDR_W-1:0];
                    end
                    if (r_pend_idx == r_count - 1'b1) begin
                        n_idx   = CNT_W'(n_pos) + 1'b1;
                        n_state = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                o_rd_en = (r_idx < r_count);
                n_pend  = o_rd_en;
                if (o_rd_en) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_pend) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = ADDR_W'(r_pend_idx - 1'b1);
                    o_wr_data = i_rd_data;
                end
                if (!o_rd_en && !r_pend) begin
                    n_count             = r_count - 1'b1;
                    n_res.removed_value = r_best;
                    n_res.status        = ST_OK;
                    n_res.fill_count    = FILL_W'(n_count);
                    n_state             = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pend_idx <= n_pend_idx;
        r_best     <= n_best;
        r_pos      <= n_pos;
        r_res      <= n_res;
    end

endmodule

`default_nettype wire

### rtl/max_extract_store.sv
// Channel  Direction  tdata (low bit up)                          tuser
// s_axis   in         item_value[31:0]                            req_type
// m_axis   out        removed_value[31:0], status[33:32],         -
//                     fill_count[41:34], zero[47:42]
//
// Insert, full insert and empty remove go straight to the done state, no scan.
// Remove-max: scan reads every entry, then shift rewrites entries above the
// maximum, limited by one memory read per cycle.
// Synchronous active-low reset empties the store; no clearing pass.
// One item in work at a time; a new item is accepted while the output
// register still holds an untaken result.
`default_nettype none

module max_extract_store
    import mes_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [VAL_W-1:0] s_axis_tdata,  // item_value
    input  wire logic             s_axis_tuser,  // req_type
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata   // removed_value, status, fill_count
);

    logic              w_res_valid;
    logic              w_res_ready;
    t_result           w_res;
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [VAL_W-1:0]  w_wr_data;
    logic              w_rd_en;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [VAL_W-1:0]  w_rd_data;

    logic    r_out_valid;
    t_result r_out;

    assign w_res_ready = !r_out_valid || m_axis_tready;

    mes_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (s_axis_tvalid),
        .o_item_ready (s_axis_tready),
        .i_req_type   (t_req'(s_axis_tuser)),
        .i_item_value ($signed(s_axis_tdata)),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_res        (w_res),
        .o_wr_en      (w_wr_en),
        .o_wr_addr    (w_wr_addr),
        .o_wr_data    (w_wr_data),
        .o_rd_en      (w_rd_en),
        .o_rd_addr    (w_rd_addr),
        .i_rd_data    (w_rd_data)
    );

    mes_ram #(
        .DEPTH  (CAPACITY),
        .WIDTH  (VAL_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_W - VAL_W - STAT_W - FILL_W)'(0),
                            r_out.fill_count, r_out.status, r_out.removed_value};

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mes_pkg::*;

    localparam int RANDOM_ITEMS = 1650;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int SETTLE       = 2 * CAPACITY + 16;

    class store_scoreboard;
        logic signed [VAL_W-1:0] stored[$];
        t_result                 expected[$];
        int                      failures;

        function new();
            failures = 0;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function void log_failure(string what, logic [OUT_W-1:0] exp_v, logic [OUT_W-1:0] act_v);
            failures++;
            if (failures <= 10) begin
                $display("mismatch %s: expected %h, got %h", what, exp_v, act_v);
            end
        endfunction

        function void note_request(t_req req, logic signed [VAL_W-1:0] value);
            t_result r;
            int      best_pos;
            r.removed_value = '0;
            r.status        = ST_OK;
            if (req == REQ_INSERT) begin
                if (stored.size() >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    stored.push_back(value);
                end
            end else if (stored.size() == 0) begin
                r.removed_value = EMPTY_VALUE;
                r.status        = ST_EMPTY;
            end else begin
                best_pos = 0;
                for (int i = 1; i < stored.size(); i++) begin
                    if (stored[i] > stored[best_pos]) begin
                        best_pos = i;
                    end
                end
                r.removed_value = stored[best_pos];
                stored.delete(best_pos);
            end
            r.fill_count = FILL_W'(stored.size());
            expected.push_back(r);
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            t_result                 want;
            logic signed [VAL_W-1:0] got_value;
            logic [STAT_W-1:0]       got_status;
            logic [FILL_W-1:0]       got_fill;
            got_value  = data[VAL_W-1:0];
            got_status = data[VAL_W+STAT_W-1:VAL_W];
            got_fill   = data[VAL_W+STAT_W+FILL_W-1:VAL_W+STAT_W];
            if (expected.size() == 0) begin
                log_failure("unexpected result", '0, data);
                return;
            end
            want = expected.pop_front();
            if (got_value !== want.removed_value) begin
                log_failure("removed_value", OUT_W'(want.removed_value), OUT_W'(got_value));
            end
            if (got_status !== want.status) begin
                log_failure("status", OUT_W'(want.status), OUT_W'(got_status));
            end
            if (got_fill !== want.fill_count) begin
                log_failure("fill_count", OUT_W'(want.fill_count), OUT_W'(got_fill));
            end
        endfunction
    endclass

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [VAL_W-1:0] s_axis_tdata  = '0;  // item_value
    logic             s_axis_tuser  = 1'b0;  // req_type
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;  // removed_value, status, fill_count, zero padding

    store_scoreboard sb = new();

    int tx_idle_pct = 19;
    int rx_idle_pct = 78;
    int cycle_count = 0;
    int sent        = 0;
    int seg_left    = 0;
    int insert_pct  = 20;
    int wait_cycles = 0;

    max_extract_store uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("max_extract_store regression: fail");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata);
        end
    end

    function automatic logic signed [VAL_W-1:0] pick_value();
        logic signed [VAL_W-1:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: v = 32'sh7fffffff;
                    1: v = 32'sh80000000;
                    2: v = 32'sd0;
                    3: v = -32'sd1;
                    default: v = 32'sd1;
                endcase
            end
            1, 2, 3: v = $signed($urandom_range(0, 7)) - 32'sd4;
            default: v = $signed($urandom());
        endcase
        return v;
    endfunction

    // call at a falling edge; returns at a falling edge
    task automatic send_request(input t_req req, input logic signed [VAL_W-1:0] value);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = $urandom();
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = req;
        s_axis_tdata  = value;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(req, value);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_request(REQ_REMOVE, 32'sd0);
        send_request(REQ_INSERT, 32'sh7fffffff);
        send_request(REQ_INSERT, 32'sh80000000);
        send_request(REQ_INSERT, 32'sd0);
        send_request(REQ_INSERT, -32'sd1);
        send_request(REQ_REMOVE, 32'sh7fffffff);
        send_request(REQ_REMOVE, -32'sd1);
        send_request(REQ_REMOVE, 32'sd0);
        send_request(REQ_REMOVE, 32'sh55555555);
        send_request(REQ_REMOVE, 32'shaaaaaaaa);
        send_request(REQ_INSERT, 32'sd3);
        send_request(REQ_INSERT, 32'sd9);
        send_request(REQ_INSERT, -32'sd9);
        send_request(REQ_INSERT, 32'sd9);
        send_request(REQ_INSERT, 32'sd2);
        send_request(REQ_REMOVE, 32'sd0);
        send_request(REQ_REMOVE, 32'sd0);
        send_request(REQ_REMOVE, 32'sd0);
        send_request(REQ_REMOVE, 32'sd0);
        send_request(REQ_REMOVE, 32'sd0);
        send_request(REQ_REMOVE, 32'sd0);
        drain_results();

        while (sent < RANDOM_ITEMS) begin
            if (sent == RANDOM_ITEMS / 3) begin
                drain_results();
                tx_idle_pct = 78;
                rx_idle_pct = 19;
            end
            if (sent == 2 * RANDOM_ITEMS / 3) begin
                drain_results();
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (seg_left == 0) begin
                seg_left   = $urandom_range(20, 220);
                insert_pct = (insert_pct > 50) ? $urandom_range(10, 30) : $urandom_range(70, 90);
            end
            if ($urandom_range(0, 99) < insert_pct) begin
                send_request(REQ_INSERT, pick_value());
            end else begin
                send_request(REQ_REMOVE, $signed($urandom()));
            end
            sent++;
            seg_left--;
        end

        drain_results();
        repeat (SETTLE) @(negedge i_clk);
        if (sb.pending() != 0) begin
            sb.log_failure("missing result", '0, '0);
        end
        if (sb.failures == 0) begin
            $display("max_extract_store regression: pass");
        end else begin
            $display("max_extract_store regression: fail");
        end
        $finish;
    end

endmodule
